FILE: rtl/assert_macros.svh
// Assertion macros for the port-level checker of the interpolator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define PIF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define PIF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked around reset.
`define PIF_ASSERT_RST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/pif_pkg.sv
// Package with the types, constants and codes of the periodic interpolator.
`timescale 1ns / 1ps
package pif_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int NP_W       = 11;
  localparam int NUM_TAPS   = 5;
  localparam int STEP_W     = 3;
  localparam int CENTER_TAP = 2;

  // Queue depths are powers of two so that the pointers wrap on their own.
  localparam int CMD_DEPTH  = 2;
  localparam int CMD_PTR_W  = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W  = $clog2(CMD_DEPTH + 1);
  localparam int RES_DEPTH  = 4;
  localparam int RES_PTR_W  = $clog2(RES_DEPTH);
  localparam int RES_CNT_W  = $clog2(RES_DEPTH + 1);

  // Input request codes.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Result status codes.
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  // Command kinds passed from the front to the back.
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_QUERY = 2'd1;
  localparam logic [1:0] CMD_ERROR = 2'd2;

  // Weight denominators.
  localparam logic [1:0] DEN_24 = 2'd0;
  localparam logic [1:0] DEN_6  = 2'd1;
  localparam logic [1:0] DEN_4  = 2'd2;

  // Widths of the weight datapath.
  localparam int F_W   = 19;   // one factor (u + c), signed
  localparam int P_W   = 36;   // product of two factors, signed
  localparam int N_W   = 72;   // full numerator plus rounding bias
  localparam int Y_W   = 22;   // numerator after the power-of-two shift
  localparam int W_W   = 19;   // weight, signed Q2.16
  localparam int D_W   = 24;   // operand of the divide-by-three
  localparam int ACC_W = 56;

  // Rounding biases and shifts: weight = floor((n + den * 2^47) / (den * 2^48)).
  localparam logic signed [N_W-1:0] BIAS_24 = N_W'(3) << 50;
  localparam logic signed [N_W-1:0] BIAS_6  = N_W'(3) << 48;
  localparam logic signed [N_W-1:0] BIAS_4  = N_W'(1) << 49;
  localparam int SHIFT_24 = 51;
  localparam int SHIFT_6  = 49;
  localparam int SHIFT_4  = 50;

  // floor(v / 3) for 0 <= v < 2^24 is (v * DIV3_MULT) >> DIV3_SHIFT.
  localparam logic [D_W-1:0] DIV3_MULT   = D_W'(11184811);
  localparam int             DIV3_SHIFT  = 25;
  localparam logic [D_W-1:0] DIV3_OFFSET = D_W'(3) << 21;
  localparam int             DIV3_BIAS_Q = 1 << 21;

  typedef struct packed {
    logic               req_type;
    logic [ADDR_W-1:0]  index;
    logic signed [31:0] sample_value;
    logic [15:0]        local_coord;
  } pif_item_t;

  typedef struct packed {
    logic signed [31:0] interp_value;
    logic               status;
  } pif_res_t;

  typedef struct packed {
    logic [1:0]                       kind;
    logic [NUM_TAPS-1:0][ADDR_W-1:0]  idx;
    logic [15:0]                      u;
    logic signed [31:0]               sample_value;
  } pif_cmd_t;

  typedef struct packed {
    logic       first;
    logic       last;
    logic       err;
    logic [1:0] den;
  } pif_flags_t;

endpackage

FILE: rtl/pif_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
module pif_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/pif_front.sv
// Front end: point count register, range check and periodic neighbor indices.
`timescale 1ns / 1ps
module pif_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  logic [pif_pkg::NP_W-1:0]     cfg_data,
  output logic                         cfg_ready,
  input  pif_pkg::pif_item_t           item,
  input  logic                         accept,
  output pif_pkg::pif_cmd_t            cmd,
  output logic                         cmd_push
);
  import pif_pkg::*;

  localparam int WR_W = NP_W + 1;

  logic [NP_W-1:0] num_points;
  logic [NP_W-1:0] n_eff;
  logic [WR_W-1:0] jw, nw, n2, sp2, jm1, jm2, jp1, jp2;
  logic            in_range;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_points <= NP_W'(MAX_POINTS);
    end else if (cfg_valid) begin
      num_points <= cfg_data;
    end
  end

  always_comb begin
    n_eff    = (num_points > NP_W'(MAX_POINTS)) ? NP_W'(MAX_POINTS) : num_points;
    jw       = WR_W'(item.index);
    nw       = WR_W'(n_eff);
    n2       = nw << 1;
    in_range = jw < nw;

    jm1 = (jw >= WR_W'(1)) ? jw - WR_W'(1) : jw + nw - WR_W'(1);
    // With a single point, j - 2 needs the modulus added twice.
    if (jw >= WR_W'(2)) begin
      jm2 = jw - WR_W'(2);
    end else if (jw + nw >= WR_W'(2)) begin
      jm2 = jw + nw - WR_W'(2);
    end else begin
      jm2 = jw + n2 - WR_W'(2);
    end
    jp1 = (jw + WR_W'(1) >= nw) ? jw + WR_W'(1) - nw : jw + WR_W'(1);
    sp2 = jw + WR_W'(2);
    if (sp2 >= n2) begin
      jp2 = sp2 - n2;
    end else if (sp2 >= nw) begin
      jp2 = sp2 - nw;
    end else begin
      jp2 = sp2;
    end

    cmd.idx[0]          = jm2[ADDR_W-1:0];
    cmd.idx[1]          = jm1[ADDR_W-1:0];
    cmd.idx[CENTER_TAP] = item.index;
    cmd.idx[3]          = jp1[ADDR_W-1:0];
    cmd.idx[4]          = jp2[ADDR_W-1:0];
    cmd.u               = item.local_coord;
    cmd.sample_value    = item.sample_value;

    if (item.req_type == REQ_WRITE) begin
      cmd.kind = CMD_WRITE;
    end else if (in_range) begin
      cmd.kind = CMD_QUERY;
    end else begin
      cmd.kind = CMD_ERROR;
    end

    // Writes outside the point range are dropped here.
    cmd_push = accept && ((item.req_type == REQ_QUERY) || in_range);
  end

endmodule

FILE: rtl/pif_cmd_fifo.sv
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
module pif_cmd_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  pif_pkg::pif_cmd_t din,
  output logic              full,
  input  logic              pop,
  output pif_pkg::pif_cmd_t dout,
  output logic              valid
);
  import pif_pkg::*;

  pif_cmd_t               entries [CMD_DEPTH];
  logic [CMD_PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CMD_CNT_W-1:0]   count;
  logic                   do_push, do_pop;

  assign full    = (count == CMD_CNT_W'(CMD_DEPTH));
  assign valid   = (count != '0);
  assign dout    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + CMD_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + CMD_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CMD_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CMD_CNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/pif_res_fifo.sv
// Result queue that drives the output channel.
`timescale 1ns / 1ps
module pif_res_fifo (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  pif_pkg::pif_res_t              din,
  input  logic                           pop,
  output pif_pkg::pif_res_t              dout,
  output logic                           empty,
  output logic [pif_pkg::RES_CNT_W-1:0]  count
);
  import pif_pkg::*;

  pif_res_t             entries [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr, rd_ptr;
  logic                 do_pop;

  assign empty  = (count == '0);
  assign dout   = entries[rd_ptr];
  assign do_pop = pop && !empty;

  // The back end only pushes when it has reserved room, so push is never dropped.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + RES_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + RES_PTR_W'(1);
      end
      if (push && !do_pop) begin
        count <= count + RES_CNT_W'(1);
      end else if (do_pop && !push) begin
        count <= count - RES_CNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/pif_back.sv
// Back end: sample store, tap sequencer and the weight and accumulate pipeline.
`timescale 1ns / 1ps
module pif_back (
  input  logic                           clk,
  input  logic                           rst,
  input  pif_pkg::pif_cmd_t              cmd,
  input  logic                           cmd_valid,
  output logic                           cmd_pop,
  input  logic [pif_pkg::RES_CNT_W-1:0]  res_count,
  output logic                           res_push,
  output pif_pkg::pif_res_t              res_data
);
  import pif_pkg::*;

  localparam int PH_W = P_W + P_W / 2;
  localparam int PL_W = P_W + P_W / 2 + 1;
  localparam int Q_W  = 2 * D_W - DIV3_SHIFT;
  localparam int PR_W = W_W + 32;

  // Sequencer.
  logic [STEP_W-1:0]    step, step_next;
  logic [RES_CNT_W-1:0] inflight;
  logic                 credit_ok, issue, mem_we;
  pif_flags_t           f0;
  logic [1:0]           den_sel;
  logic [ADDR_W-1:0]    mem_addr;
  logic [31:0]          rdata;

  // Factor selection.
  logic signed [F_W-1:0]   uext, fm2, fm1, fp1, fp2, nm1, nm2;
  logic signed [F_W-1:0]   xa, ya, xb, yb;
  logic signed [2*F_W-1:0] pa, pb;

  // Pipeline registers.
  logic                      v1, v2, v3, v4, v5, v6, v7, v8;
  pif_flags_t                f1, f2, f3, f4, f5, f6, f7;
  logic signed [P_W-1:0]     a1, b1;
  logic signed [PH_W-1:0]    ph2;
  logic signed [PL_W-1:0]    pl2;
  logic signed [31:0]        smp2, smp3, smp4, smp5, smp6;
  logic signed [N_W-1:0]     n3;
  logic signed [N_W-1:0]     xs, xsh;
  logic signed [Y_W-1:0]     y4, y5;
  logic [D_W-1:0]            yp;
  logic [2*D_W-1:0]          qp5;
  logic [Q_W-1:0]            q6;
  logic [Q_W-1:0]            qw;
  logic signed [W_W-1:0]     w6;
  logic signed [PR_W-1:0]    p7;
  logic signed [ACC_W-1:0]   acc, acc_next, tot8, rnd, rq;
  logic                      err8;

  // ---------------------------------------------------------------- issue
  assign credit_ok = ({1'b0, inflight} + {1'b0, res_count}) < (RES_CNT_W + 1)'(RES_DEPTH);

  always_comb begin
    issue     = 1'b0;
    mem_we    = 1'b0;
    cmd_pop   = 1'b0;
    step_next = step;
    f0        = '0;
    f0.den    = den_sel;
    if (cmd_valid) begin
      unique case (cmd.kind)
        CMD_WRITE: begin
          mem_we  = 1'b1;
          cmd_pop = 1'b1;
        end
        CMD_QUERY: begin
          // A new query starts only when its result is sure to find room.
          if ((step != '0) || credit_ok) begin
            issue    = 1'b1;
            f0.first = (step == '0);
            if (step == STEP_W'(NUM_TAPS - 1)) begin
              f0.last   = 1'b1;
              cmd_pop   = 1'b1;
              step_next = '0;
            end else begin
              step_next = step + STEP_W'(1);
            end
          end
        end
        CMD_ERROR: begin
          if (credit_ok) begin
            issue    = 1'b1;
            f0.first = 1'b1;
            f0.last  = 1'b1;
            f0.err   = 1'b1;
            cmd_pop  = 1'b1;
          end
        end
        default: begin
          cmd_pop = 1'b1;
        end
      endcase
    end
  end

  assign mem_addr = mem_we ? cmd.idx[CENTER_TAP] : cmd.idx[step];

  always_ff @(posedge clk) begin
    if (rst) begin
      step     <= '0;
      inflight <= '0;
    end else begin
      step <= step_next;
      if (issue && f0.first && !res_push) begin
        inflight <= inflight + RES_CNT_W'(1);
      end else if (res_push && !(issue && f0.first)) begin
        inflight <= inflight - RES_CNT_W'(1);
      end
    end
  end

  pif_ram #(
    .WIDTH(32),
    .DEPTH(MAX_POINTS)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(cmd.sample_value),
    .rdata(rdata)
  );

  // ------------------------------------------------- factor pair products
  always_comb begin
    uext = F_W'(cmd.u);
    fm2  = uext - F_W'(131072);
    fm1  = uext - F_W'(65536);
    fp1  = uext + F_W'(65536);
    fp2  = uext + F_W'(131072);
    nm1  = F_W'(65536) - uext;
    nm2  = F_W'(131072) - uext;
    xa   = '0;
    ya   = '0;
    xb   = '0;
    yb   = '0;
    den_sel = DEN_24;
    unique case (step)
      3'd0: begin
        xa = fp1; ya = fm2; xb = uext; yb = fm1; den_sel = DEN_24;
      end
      3'd1: begin
        xa = fp2; ya = nm1; xb = uext; yb = fm2; den_sel = DEN_6;
      end
      3'd2: begin
        xa = fp2; ya = fp1; xb = fm1; yb = fm2; den_sel = DEN_4;
      end
      3'd3: begin
        xa = fp2; ya = nm2; xb = uext; yb = fp1; den_sel = DEN_6;
      end
      3'd4: begin
        xa = fp2; ya = fm1; xb = uext; yb = fp1; den_sel = DEN_24;
      end
      default: begin
        den_sel = DEN_24;
      end
    endcase
    pa = xa * ya;
    pb = xb * yb;
  end

  // Stage 1: pair products. Stage 2: split product of the pairs.
  always_ff @(posedge clk) begin
    a1   <= pa[P_W-1:0];
    b1   <= pb[P_W-1:0];
    f1   <= f0;
    ph2  <= a1 * $signed(b1[P_W-1:P_W/2]);
    pl2  <= a1 * $signed({1'b0, b1[P_W/2-1:0]});
    smp2 <= $signed(rdata);
    f2   <= f1;
  end

  // Stage 3: full numerator.
  always_ff @(posedge clk) begin
    n3   <= (N_W'(ph2) <<< (P_W / 2)) + N_W'(pl2);
    smp3 <= smp2;
    f3   <= f2;
  end

  // Stage 4: rounding bias and power-of-two part of the denominator.
  always_comb begin
    case (f3.den)
      DEN_6: begin
        xs  = n3 + BIAS_6;
        xsh = xs >>> SHIFT_6;
      end
      DEN_4: begin
        xs  = n3 + BIAS_4;
        xsh = xs >>> SHIFT_4;
      end
      default: begin
        xs  = n3 + BIAS_24;
        xsh = xs >>> SHIFT_24;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    y4   <= xsh[Y_W-1:0];
    smp4 <= smp3;
    f4   <= f3;
  end

  // Stage 5: floor division by three on an offset that keeps the operand positive.
  assign yp = {{(D_W - Y_W){y4[Y_W-1]}}, y4} + DIV3_OFFSET;

  always_ff @(posedge clk) begin
    qp5  <= yp * DIV3_MULT;
    y5   <= y4;
    smp5 <= smp4;
    f5   <= f4;
  end

  // Stage 6: weight in Q2.16.
  assign q6 = qp5[2*D_W-1:DIV3_SHIFT];
  assign qw = q6 - Q_W'(DIV3_BIAS_Q);

  always_ff @(posedge clk) begin
    w6   <= (f5.den == DEN_4) ? y5[W_W-1:0] : $signed(qw[W_W-1:0]);
    smp6 <= smp5;
    f6   <= f5;
  end

  // Stage 7: weighted sample.
  always_ff @(posedge clk) begin
    p7 <= w6 * smp6;
    f7 <= f6;
  end

  // Stage 8: accumulate over the five taps.
  assign acc_next = (f7.first ? ACC_W'(0) : acc) + ACC_W'(p7);

  always_ff @(posedge clk) begin
    if (v7) begin
      acc <= acc_next;
    end
    if (v7 && f7.last) begin
      tot8 <= acc_next;
      err8 <= f7.err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      v8 <= v7 && f7.last;
    end
  end

  // Round half up to Q16.16 and saturate.
  always_comb begin
    rnd      = tot8 + ACC_W'(32768);
    rq       = rnd >>> 16;
    res_push = v8;
    if (err8) begin
      res_data.interp_value = '0;
      res_data.status       = STATUS_RANGE;
    end else begin
      res_data.status = STATUS_OK;
      if ((&rq[ACC_W-1:31]) || !(|rq[ACC_W-1:31])) begin
        res_data.interp_value = rq[31:0];
      end else if (rq[ACC_W-1]) begin
        res_data.interp_value = 32'sh8000_0000;
      end else begin
        res_data.interp_value = 32'sh7FFF_FFFF;
      end
    end
  end

endmodule

FILE: rtl/periodic_five_point_interpolator.sv
// Periodic grid: sample writes and fourth-order five-point interpolation queries.
//
// Input channel: an item is taken at a clock edge with push high and full low.
// A write item (req_type 0) stores sample_value at index when index is below the
// point count; otherwise it is dropped. A query item (req_type 1) yields exactly
// one result: interp_value from samples index-2 .. index+2 (wrapping at the point
// count) weighted at local_coord, or status 1 and value 0 when index is out of range.
// Results leave in order through a four-entry queue: empty low shows one, pop takes it.
// Configuration: cfg_data is the point count, written when cfg_valid and cfg_ready
// are high; cfg_ready is always high. Values above 1024 act as 1024.
// Sample memory: a query holds the single-port sample memory for one read per tap;
// a write is a single store and an out-of-range query a single pipeline pass, and a
// next command can start while earlier taps are still in the pipeline. Result path:
// the five memory reads feed the eight-stage weight and accumulate pipeline behind
// the memory, which pushes the five-tap sum into the result queue.
// Reset: queues empty, point count returns to 1024; the sample store is not cleared,
// and entries are expected to be written before they are read.
// When the receiver stalls, results collect in the queue; new queries wait until
// a slot is reserved for them, the command queue fills and full rises.
`timescale 1ns / 1ps
module periodic_five_point_interpolator (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  pif_pkg::pif_item_t        item,
  output logic                      empty,
  input  logic                      pop,
  output pif_pkg::pif_res_t         result,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [pif_pkg::NP_W-1:0]  cfg_data
);
  import pif_pkg::*;

  logic                 accept;
  pif_cmd_t             front_cmd, head_cmd;
  logic                 front_push, head_valid, head_pop;
  logic [RES_CNT_W-1:0] res_count;
  logic                 res_push;
  pif_res_t             res_data;

  assign accept = push && !full;

  pif_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_data (cfg_data),
    .cfg_ready(cfg_ready),
    .item     (item),
    .accept   (accept),
    .cmd      (front_cmd),
    .cmd_push (front_push)
  );

  pif_cmd_fifo u_cmd_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (front_push),
    .din  (front_cmd),
    .full (full),
    .pop  (head_pop),
    .dout (head_cmd),
    .valid(head_valid)
  );

  pif_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd      (head_cmd),
    .cmd_valid(head_valid),
    .cmd_pop  (head_pop),
    .res_count(res_count),
    .res_push (res_push),
    .res_data (res_data)
  );

  pif_res_fifo u_res_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .din  (res_data),
    .pop  (pop),
    .dout (result),
    .empty(empty),
    .count(res_count)
  );

endmodule

FILE: rtl/pif_checker.sv
// Port-level checker for the interpolator and its bind statement.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pif_checker (
  input logic              clk,
  input logic              rst,
  input logic              push,
  input logic              full,
  input logic              pop,
  input logic              empty,
  input pif_pkg::pif_res_t result
);
  import pif_pkg::*;

  // A waiting result that is not taken stays and does not change.
  `PIF_ASSERT_NXT(a_result_held, !empty && !pop, !empty && $stable(result), "result lost while stalled")

  // Reset leaves both queues empty.
  `PIF_ASSERT_RST_NXT(a_reset_empty, rst, empty && !full, "queues not empty after reset")

  // An out-of-range result carries a zero value.
  `PIF_ASSERT_IMP(a_range_zero, !empty && (result.status == STATUS_RANGE), result.interp_value == 0, "range error with nonzero value")

  // The input side can only fill up after a transaction was taken.
  `PIF_ASSERT_IMP(a_full_after_push, $rose(full), $past(push), "full rose without a push")

endmodule

bind periodic_five_point_interpolator pif_checker u_pif_checker (.*);
